[src/tssg_pkg.sv]
// ---------------------------------------------------------------------------
// Triangle span generator package
// Shared types, constants and arithmetic helpers for the span generator.
// ---------------------------------------------------------------------------
package tssg_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int SLOPE_FRAC_BITS = 16;
  localparam int ROW_BITS        = 12;

  localparam int CW        = 16;
  localparam int ACC_W     = 32;
  localparam int RX_W      = 14;
  localparam int DX_W      = RX_W + 1;
  localparam int MX_W      = 18;
  localparam int MUL_W     = 2 * (CW + 1);
  localparam int DIV_NW    = 37;
  localparam int DIV_DW    = 17;
  localparam int DIV_CNT_W = $clog2(DIV_NW + 1);
  localparam int RND_HALF  = (1 << COORD_FRAC_BITS) >> 1;

  typedef logic signed [ROW_BITS-1:0] row_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [RX_W-1:0]     rx_t;

  typedef struct packed {
    logic                 command;
    logic signed [CW-1:0] vert0_x;
    logic signed [CW-1:0] vert0_y;
    logic signed [CW-1:0] vert1_x;
    logic signed [CW-1:0] vert1_y;
    logic signed [CW-1:0] vert2_x;
    logic signed [CW-1:0] vert2_y;
    logic [31:0]          fill_color;
  } tssg_in_t;

  typedef struct packed {
    logic        span_valid;
    row_t        span_row;
    row_t        span_x_first;
    row_t        span_x_second;
    logic [31:0] span_color;
    logic        span_last;
  } tssg_out_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_DOWN_MORE = 2'd1,
    PH_UP_LAST   = 2'd2,
    PH_DOWN_LAST = 2'd3
  } tssg_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_CLASS,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } tssg_state_t;

  typedef enum logic [2:0] {
    OP_MID,
    OP_A10,
    OP_BM0,
    OP_C21,
    OP_D2M,
    OP_A20,
    OP_B21
  } tssg_op_t;

  localparam logic CMD_LOAD = 1'b0;

  typedef struct packed {
    logic     latch_in;
    logic     sort;
    logic     init_tri;
    logic     mul;
    logic     div_start;
    tssg_op_t div_op;
    logic     emit;
  } tssg_cmd_t;

  typedef struct packed {
    logic degen;
    logic upper_flat;
    logic div_done;
    logic out_busy;
  } tssg_sts_t;

  function automatic rx_t round_coord(input logic signed [MX_W-1:0] v);
    logic [MX_W-1:0] mag;
    logic [MX_W-1:0] r;
    mag = v[MX_W-1] ? MX_W'(-v) : MX_W'(v);
    r   = (mag + MX_W'(RND_HALF)) >> COORD_FRAC_BITS;
    return v[MX_W-1] ? RX_W'(-r) : RX_W'(r);
  endfunction

  function automatic row_t sat_row(input rx_t v);
    localparam rx_t RMAX = rx_t'((1 << (ROW_BITS - 1)) - 1);
    localparam rx_t RMIN = rx_t'(-(1 << (ROW_BITS - 1)));
    if (v > RMAX) begin
      return row_t'(RMAX);
    end else if (v < RMIN) begin
      return row_t'(RMIN);
    end
    return row_t'(v);
  endfunction

  function automatic acc_t sat_acc(input logic signed [DIV_NW:0] v);
    localparam logic signed [DIV_NW:0] AMAX = (DIV_NW+1)'((64'sd1 <<< (ACC_W - 1)) - 1);
    localparam logic signed [DIV_NW:0] AMIN = (DIV_NW+1)'(-(64'sd1 <<< (ACC_W - 1)));
    if (v > AMAX) begin
      return acc_t'(AMAX);
    end else if (v < AMIN) begin
      return acc_t'(AMIN);
    end
    return acc_t'(v);
  endfunction

  function automatic row_t acc_to_pixel(input acc_t a);
    localparam logic [ACC_W:0] HALF = (ACC_W+1)'(1) << (SLOPE_FRAC_BITS - 1);
    localparam logic [ACC_W:0] PMAX = (ACC_W+1)'((1 << (ROW_BITS - 1)) - 1);
    logic [ACC_W:0] mag;
    logic [ACC_W:0] r;
    mag = a[ACC_W-1] ? (ACC_W+1)'(-{a[ACC_W-1], a}) : (ACC_W+1)'({1'b0, a});
    r   = (mag + HALF) >> SLOPE_FRAC_BITS;
    if (!a[ACC_W-1]) begin
      return (r > PMAX) ? row_t'(PMAX) : row_t'(r);
    end
    return (r > PMAX) ? row_t'(-(PMAX + 1)) : row_t'(-r);
  endfunction

  function automatic acc_t to_acc(input logic signed [CW-1:0] x);
    return acc_t'(x) <<< (SLOPE_FRAC_BITS - COORD_FRAC_BITS);
  endfunction

endpackage

[src/tssg_div.sv]
// ---------------------------------------------------------------------------
// Span generator divider
// Restoring divider, one quotient bit per cycle, rounding to nearest with
// ties away from zero and a zero result for a zero divisor.
// ---------------------------------------------------------------------------
module tssg_div
  import tssg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIV_NW-1:0] num_i,
  input  logic signed [DIV_DW:0]   den_i,
  output logic                     done,
  output logic signed [DIV_NW:0]   quo_o
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NW-1:0]    quo_r, quo_nxt;
  logic [DIV_DW-1:0]    rem_r, rem_nxt;
  logic [DIV_DW-1:0]    den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic                 zero_r, zero_nxt;

  logic [DIV_NW-1:0]    an;
  logic [DIV_DW-1:0]    ad;
  logic [DIV_DW:0]      trial;
  logic                 fits;

  always_comb begin
    an    = num_i[DIV_NW-1] ? DIV_NW'(-num_i) : DIV_NW'(num_i);
    ad    = den_i[DIV_DW] ? DIV_DW'(-den_i) : DIV_DW'(den_i);
    trial = {rem_r, quo_r[DIV_NW-1]};
    fits  = trial >= {1'b0, den_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NW);
      quo_nxt  = an + DIV_NW'(ad >> 1);
      rem_nxt  = '0;
      den_nxt  = ad;
      neg_nxt  = num_i[DIV_NW-1] ^ den_i[DIV_DW];
      zero_nxt = (ad == '0);
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_NW-2:0], fits};
      rem_nxt = fits ? DIV_DW'(trial - {1'b0, den_r}) : DIV_DW'(trial);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  assign done  = done_r;
  assign quo_o = zero_r ? '0 :
                 (neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r}));

endmodule

[src/tssg_dp.sv]
// ---------------------------------------------------------------------------
// Span generator datapath
// Vertex sort, edge setup, divider operand selection, edge walk and the
// output register.
// ---------------------------------------------------------------------------
module tssg_dp
  import tssg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tssg_in_t  in_data,
  input  tssg_cmd_t cmd,
  output tssg_sts_t sts,
  input  logic      out_stall,
  output logic      out_valid,
  output tssg_out_t out_data
);

  tssg_in_t             in_r;
  logic signed [CW-1:0] x_r [3];
  logic signed [CW-1:0] y_r [3];
  rx_t                  rx_r [3];
  rx_t                  ry_r [3];
  logic signed [MUL_W-1:0] mul_r;
  rx_t                  rmx_r;

  acc_t        ax_r, bx_r, as_r, bs_r;
  row_t        cur_r, end_r;
  tssg_phase_t phase_r;
  logic [31:0] color_r;

  acc_t        sec_as_r, sec_bs_r, sec_x_r;
  row_t        sec_row_r, sec_end_r;

  logic        out_valid_r;
  tssg_out_t   out_r;
  tssg_out_t   out_nxt;

  logic signed [CW-1:0] sx [3];
  logic signed [CW-1:0] sy [3];
  logic signed [CW-1:0] tx, ty;

  logic signed [DX_W-1:0]  sl_dx;
  logic signed [DX_W-1:0]  sl_dy;
  logic signed [DIV_NW-1:0] div_num;
  logic signed [DIV_DW:0]   div_den;
  logic                     div_done;
  logic signed [DIV_NW:0]   div_quo;
  logic signed [MX_W-1:0]   mx;

  always_comb begin
    tx = '0;
    ty = '0;
    sx[0] = in_r.vert0_x; sy[0] = in_r.vert0_y;
    sx[1] = in_r.vert1_x; sy[1] = in_r.vert1_y;
    sx[2] = in_r.vert2_x; sy[2] = in_r.vert2_y;
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
    if (sy[1] > sy[2]) begin
      tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
  end

  always_comb begin
    sl_dx = '0;
    sl_dy = '0;
    case (cmd.div_op)
      OP_A10: begin
        sl_dx = DX_W'(rx_r[1]) - DX_W'(rx_r[0]);
        sl_dy = DX_W'(ry_r[1]) - DX_W'(ry_r[0]);
      end
      OP_BM0: begin
        sl_dx = DX_W'(rmx_r) - DX_W'(rx_r[0]);
        sl_dy = DX_W'(ry_r[1]) - DX_W'(ry_r[0]);
      end
      OP_C21, OP_B21: begin
        sl_dx = DX_W'(rx_r[2]) - DX_W'(rx_r[1]);
        sl_dy = DX_W'(ry_r[2]) - DX_W'(ry_r[1]);
      end
      OP_D2M: begin
        sl_dx = DX_W'(rx_r[2]) - DX_W'(rmx_r);
        sl_dy = DX_W'(ry_r[2]) - DX_W'(ry_r[1]);
      end
      OP_A20: begin
        sl_dx = DX_W'(rx_r[2]) - DX_W'(rx_r[0]);
        sl_dy = DX_W'(ry_r[2]) - DX_W'(ry_r[0]);
      end
      default: begin
        sl_dx = '0;
        sl_dy = '0;
      end
    endcase
    if (cmd.div_op == OP_MID) begin
      div_num = DIV_NW'(mul_r);
      div_den = (DIV_DW+1)'((CW+1)'(y_r[2]) - (CW+1)'(y_r[0]));
    end else begin
      div_num = DIV_NW'(sl_dx) <<< SLOPE_FRAC_BITS;
      div_den = (DIV_DW+1)'(sl_dy);
    end
    mx = MX_W'(x_r[0]) + MX_W'(div_quo);
  end

  always_comb begin
    out_nxt = '0;
    if (phase_r != PH_IDLE) begin
      out_nxt.span_valid    = 1'b1;
      out_nxt.span_row      = cur_r;
      out_nxt.span_x_first  = acc_to_pixel(ax_r);
      out_nxt.span_x_second = acc_to_pixel(bx_r);
      out_nxt.span_color    = color_r;
      out_nxt.span_last     = (cur_r == end_r) && (phase_r != PH_DOWN_MORE);
    end
  end

  tssg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num_i (div_num),
    .den_i (div_den),
    .done  (div_done),
    .quo_o (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_data;
    end
    if (cmd.sort) begin
      for (int i = 0; i < 3; i++) begin
        x_r[i]  <= sx[i];
        y_r[i]  <= sy[i];
        rx_r[i] <= round_coord(MX_W'(sx[i]));
        ry_r[i] <= round_coord(MX_W'(sy[i]));
      end
    end
    if (cmd.mul) begin
      mul_r <= ((CW+1)'(x_r[2]) - (CW+1)'(x_r[0])) * ((CW+1)'(y_r[1]) - (CW+1)'(y_r[0]));
    end
    if (cmd.init_tri) begin
      sec_x_r   <= to_acc(x_r[2]);
      sec_row_r <= sat_row(round_coord(MX_W'(y_r[2])));
      sec_end_r <= sat_row(round_coord(MX_W'(y_r[1])));
    end
    if (div_done) begin
      case (cmd.div_op)
        OP_C21:  sec_as_r <= sat_acc(div_quo);
        OP_D2M:  sec_bs_r <= sat_acc(div_quo);
        OP_MID:  rmx_r    <= round_coord(mx);
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r        <= '0;
      bx_r        <= '0;
      as_r        <= '0;
      bs_r        <= '0;
      cur_r       <= '0;
      end_r       <= '0;
      phase_r     <= PH_IDLE;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !cmd.emit) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.init_tri) begin
        color_r <= in_r.fill_color;
        if (sts.degen) begin
          as_r    <= '0;
          bs_r    <= '0;
          ax_r    <= to_acc(x_r[0]);
          bx_r    <= to_acc(x_r[0]);
          cur_r   <= sat_row(round_coord(MX_W'(y_r[0])));
          end_r   <= sat_row(round_coord(MX_W'(y_r[1])));
          phase_r <= PH_DOWN_LAST;
        end else if (sts.upper_flat) begin
          ax_r    <= to_acc(x_r[2]);
          bx_r    <= to_acc(x_r[2]);
          cur_r   <= sat_row(round_coord(MX_W'(y_r[2])));
          end_r   <= sat_row(round_coord(MX_W'(y_r[0])));
          phase_r <= PH_UP_LAST;
        end else begin
          ax_r    <= to_acc(x_r[0]);
          bx_r    <= to_acc(x_r[0]);
          cur_r   <= sat_row(round_coord(MX_W'(y_r[0])));
          end_r   <= sat_row(round_coord(MX_W'(y_r[1])));
          phase_r <= PH_DOWN_MORE;
        end
      end
      if (div_done) begin
        case (cmd.div_op)
          OP_A10, OP_A20: as_r <= sat_acc(div_quo);
          OP_BM0, OP_B21: bs_r <= sat_acc(div_quo);
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (phase_r != PH_IDLE) begin
          if (cur_r == end_r) begin
            if (phase_r == PH_DOWN_MORE) begin
              as_r    <= sec_as_r;
              bs_r    <= sec_bs_r;
              ax_r    <= sec_x_r;
              bx_r    <= sec_x_r;
              cur_r   <= sec_row_r;
              end_r   <= sec_end_r;
              phase_r <= PH_UP_LAST;
            end else begin
              phase_r <= PH_IDLE;
            end
          end else if (phase_r == PH_UP_LAST) begin
            cur_r <= cur_r - 1'b1;
            ax_r  <= sat_acc((DIV_NW+1)'(ax_r) - (DIV_NW+1)'(as_r));
            bx_r  <= sat_acc((DIV_NW+1)'(bx_r) - (DIV_NW+1)'(bs_r));
          end else begin
            cur_r <= cur_r + 1'b1;
            ax_r  <= sat_acc((DIV_NW+1)'(ax_r) + (DIV_NW+1)'(as_r));
            bx_r  <= sat_acc((DIV_NW+1)'(bx_r) + (DIV_NW+1)'(bs_r));
          end
        end
      end
    end
  end

  assign sts.degen      = (ry_r[0] == ry_r[2]);
  assign sts.upper_flat = (ry_r[0] == ry_r[1]);
  assign sts.div_done   = div_done;
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("span overwrites a result that is still held");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && phase_r == PH_IDLE) |=> !out_r.span_valid)
    else $error("span produced with no triangle pending");

endmodule

[src/tssg_ctrl.sv]
// ---------------------------------------------------------------------------
// Span generator controller
// Sequences triangle setup, the midpoint and edge-step divisions and the
// emission of one span per transfer.
// ---------------------------------------------------------------------------
module tssg_ctrl
  import tssg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  output logic      in_stall,
  input  tssg_sts_t sts,
  output tssg_cmd_t cmd
);

  tssg_state_t state_r, state_nxt;
  tssg_op_t    op_r, op_nxt;
  logic        last_op;

  always_comb begin
    last_op = (op_r == OP_D2M) || (op_r == OP_B21);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_command == CMD_LOAD) ? ST_SORT : ST_EMIT;
        end
      end
      ST_SORT: state_nxt = ST_CLASS;
      ST_CLASS: begin
        if (sts.degen) begin
          state_nxt = ST_EMIT;
        end else if (sts.upper_flat) begin
          state_nxt = ST_DIV_GO;
          op_nxt    = OP_A20;
        end else begin
          state_nxt = ST_MUL;
          op_nxt    = OP_MID;
        end
      end
      ST_MUL: state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          if (last_op) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_DIV_GO;
            case (op_r)
              OP_MID:  op_nxt = OP_A10;
              OP_A10:  op_nxt = OP_BM0;
              OP_BM0:  op_nxt = OP_C21;
              OP_C21:  op_nxt = OP_D2M;
              OP_A20:  op_nxt = OP_B21;
              default: op_nxt = op_r;
            endcase
          end
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.div_op    = op_r;
    cmd.latch_in  = (state_r == ST_IDLE) && in_valid;
    cmd.sort      = (state_r == ST_SORT);
    cmd.init_tri  = (state_r == ST_CLASS);
    cmd.mul       = (state_r == ST_MUL);
    cmd.div_start = (state_r == ST_DIV_GO);
    cmd.emit      = (state_r == ST_EMIT) && !sts.out_busy;
    in_stall      = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_MID;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SORT || state_r == ST_EMIT))
    else $error("accepted transfer did not start load or emit");

endmodule

[src/triangle_scanline_span_generator_unit.sv]
// ---------------------------------------------------------------------------
// Triangle scanline span generator
// Loads a triangle and produces one horizontal span per transfer.
// ---------------------------------------------------------------------------
// An advance transfer is accepted in the idle state and then, once the output
// is not held, steps both edge accumulators and writes the output register. A
// load transfer sorts and rounds the vertices and then runs its divisions one
// after another through a single restoring divider: a general triangle needs
// the midpoint division and a step division per edge and half, a flat-top
// triangle one per edge, a degenerate none before its first span. A finished
// span waits in the output register while the next transfer is accepted.
module triangle_scanline_span_generator_unit
  import tssg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tssg_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tssg_out_t out_data
);

  tssg_cmd_t cmd;
  tssg_sts_t sts;

  tssg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  tssg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[test/tb_triangle_scanline_span_generator_unit.sv]
// ---------------------------------------------------------------------------
// Triangle scanline span generator testbench
// Drives random and directed triangle loads and span advances through the
// valid/stall channels, predicts every span in the testbench and compares
// each output transfer field by field in order.
// ---------------------------------------------------------------------------
module tb_triangle_scanline_span_generator_unit;
  import tssg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_MAX = (1 << (ROW_BITS - 1)) - 1;
  localparam int ROW_MIN = -(1 << (ROW_BITS - 1));

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  tssg_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  tssg_out_t out_data;

  triangle_scanline_span_generator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Span walker state.
  longint      a_x, b_x, a_step, b_step, cur_row, last_row;
  tssg_phase_t phase;
  longint      up_a_step, up_b_step, up_x, up_row, up_end;
  logic [31:0] color_q;

  tssg_in_t  pending_items[$];
  tssg_out_t span_queue[$];
  int        error_count;
  bit        stim_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** triangle_scanline_span_generator_unit: FAILED **");
    $finish;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_shift(longint v, int fb);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + ((64'sd1 << fb) >> 1)) >>> fb;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint div_nearest(longint n, longint d);
    longint an, ad, q;
    if (d == 0) return 0;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (an + ad / 2) / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint edge_slope(longint dx, longint dy);
    return clip(div_nearest(dx * (64'sd1 << SLOPE_FRAC_BITS), dy), -(64'sd1 << 31),
                (64'sd1 << 31) - 1);
  endfunction

  function automatic longint start_acc(longint xq);
    return xq * (64'sd1 << (SLOPE_FRAC_BITS - COORD_FRAC_BITS));
  endfunction

  function automatic longint pixel_row(longint vq);
    return clip(round_shift(vq, COORD_FRAC_BITS), ROW_MIN, ROW_MAX);
  endfunction

  function automatic longint acc_add(longint a, longint b);
    return clip(a + b, -(64'sd1 << 31), (64'sd1 << 31) - 1);
  endfunction

  task automatic load_triangle(input tssg_in_t it);
    longint x[3], y[3], rx[3], ry[3], t, mx, rmx;
    int a;
    x[0] = it.vert0_x; y[0] = it.vert0_y;
    x[1] = it.vert1_x; y[1] = it.vert1_y;
    x[2] = it.vert2_x; y[2] = it.vert2_y;
    for (int i = 0; i < 3; i++) begin
      a = (i == 1) ? 1 : 0;
      if (y[a] > y[a + 1]) begin
        t = x[a]; x[a] = x[a + 1]; x[a + 1] = t;
        t = y[a]; y[a] = y[a + 1]; y[a + 1] = t;
      end
    end
    for (int i = 0; i < 3; i++) begin
      rx[i] = round_shift(x[i], COORD_FRAC_BITS);
      ry[i] = round_shift(y[i], COORD_FRAC_BITS);
    end
    color_q = it.fill_color;
    if (ry[0] == ry[2]) begin
      a_step = edge_slope(rx[1] - rx[0], ry[1] - ry[0]);
      b_step = edge_slope(rx[2] - rx[0], ry[2] - ry[0]);
      a_x = start_acc(x[0]); b_x = a_x;
      cur_row = pixel_row(y[0]); last_row = pixel_row(y[1]);
      phase = PH_DOWN_LAST;
    end else if (ry[0] == ry[1]) begin
      a_step = edge_slope(rx[2] - rx[0], ry[2] - ry[0]);
      b_step = edge_slope(rx[2] - rx[1], ry[2] - ry[1]);
      a_x = start_acc(x[2]); b_x = a_x;
      cur_row = pixel_row(y[2]); last_row = pixel_row(y[0]);
      phase = PH_UP_LAST;
    end else begin
      mx = x[0] + div_nearest((x[2] - x[0]) * (y[1] - y[0]), y[2] - y[0]);
      rmx = round_shift(mx, COORD_FRAC_BITS);
      a_step = edge_slope(rx[1] - rx[0], ry[1] - ry[0]);
      b_step = edge_slope(rmx - rx[0], ry[1] - ry[0]);
      a_x = start_acc(x[0]); b_x = a_x;
      cur_row = pixel_row(y[0]); last_row = pixel_row(y[1]);
      up_a_step = edge_slope(rx[2] - rx[1], ry[2] - ry[1]);
      up_b_step = edge_slope(rx[2] - rmx, ry[2] - ry[1]);
      up_x = start_acc(x[2]);
      up_row = pixel_row(y[2]); up_end = pixel_row(y[1]);
      phase = PH_DOWN_MORE;
    end
  endtask

  task automatic predict_span(input tssg_in_t it);
    tssg_out_t r;
    r = '0;
    if (it.command == CMD_LOAD) load_triangle(it);
    if (phase != PH_IDLE) begin
      r.span_valid    = 1'b1;
      r.span_row      = row_t'(cur_row);
      r.span_x_first  = row_t'(clip(round_shift(a_x, SLOPE_FRAC_BITS), ROW_MIN, ROW_MAX));
      r.span_x_second = row_t'(clip(round_shift(b_x, SLOPE_FRAC_BITS), ROW_MIN, ROW_MAX));
      r.span_color    = color_q;
      if (cur_row == last_row) begin
        if (phase == PH_DOWN_MORE) begin
          a_step = up_a_step; b_step = up_b_step;
          a_x = up_x; b_x = up_x;
          cur_row = up_row; last_row = up_end;
          phase = PH_UP_LAST;
        end else begin
          phase = PH_IDLE;
          r.span_last = 1'b1;
        end
      end else if (phase == PH_UP_LAST) begin
        cur_row--;
        a_x = acc_add(a_x, -a_step); b_x = acc_add(b_x, -b_step);
      end else begin
        cur_row++;
        a_x = acc_add(a_x, a_step); b_x = acc_add(b_x, b_step);
      end
    end
    span_queue.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    error_count++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1200)) - 600);
      default: return 16'($signed($urandom_range(0, 160)) - 80);
    endcase
  endfunction

  task automatic add_item(input logic cmd, input int mode);
    tssg_in_t it;
    it.command    = cmd;
    it.vert0_x    = rand_coord(mode);
    it.vert0_y    = rand_coord(mode);
    it.vert1_x    = rand_coord(mode);
    it.vert1_y    = rand_coord(mode);
    it.vert2_x    = rand_coord(mode);
    it.vert2_y    = rand_coord(mode);
    it.fill_color = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic add_tri(input logic signed [15:0] x0, y0, x1, y1, x2, y2,
                         input logic [31:0] c, input int advances);
    tssg_in_t it;
    it = '{CMD_LOAD, x0, y0, x1, y1, x2, y2, c};
    pending_items.push_back(it);
    for (int i = 0; i < advances; i++) begin
      it.command = ~CMD_LOAD;
      it.fill_color = ~it.fill_color;
      pending_items.push_back(it);
    end
  endtask

  // Driver.
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) void'(pending_items.pop_front());
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items[0];
        in_valid <= 1'b1;
        predict_span(pending_items[0]);
        in_gap   <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor.
  int out_gap;
  always @(posedge clk) begin
    tssg_out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (span_queue.size() == 0) begin
          report_mismatch("unexpected span", 0, 0);
        end else begin
          e = span_queue.pop_front();
          if (out_data.span_valid != e.span_valid)
            report_mismatch("span_valid", out_data.span_valid, e.span_valid);
          if (out_data.span_row != e.span_row)
            report_mismatch("span_row", out_data.span_row, e.span_row);
          if (out_data.span_x_first != e.span_x_first)
            report_mismatch("span_x_first", out_data.span_x_first, e.span_x_first);
          if (out_data.span_x_second != e.span_x_second)
            report_mismatch("span_x_second", out_data.span_x_second, e.span_x_second);
          if (out_data.span_color != e.span_color)
            report_mismatch("span_color", out_data.span_color, e.span_color);
          if (out_data.span_last != e.span_last)
            report_mismatch("span_last", out_data.span_last, e.span_last);
        end
      end
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap   <= gap_len();
      end
    end
  end

  initial begin
    int n, mode, len;
    error_count = 0;
    phase       = PH_IDLE;
    a_x = 0; b_x = 0; a_step = 0; b_step = 0; cur_row = 0; last_row = 0;
    color_q     = '0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;

    // Advances while idle, then extremes and general and flat-top triangles.
    add_item(~CMD_LOAD, 0);
    add_item(~CMD_LOAD, 0);
    add_tri(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
            32'hffff_ffff, 2);
    add_tri(16'sd40, 16'sd40, 16'sd200, 16'sd47, 16'sd8, 16'sd56, 32'h0, 1);
    add_tri(16'sd0, 16'sd16, 16'sd64, 16'sd16, 16'sd32, 16'sd80, 32'h1234_5678, 5);
    add_tri(16'sd0, 16'sd0, 16'sd80, 16'sd40, 16'sd8, 16'sd100, 32'h8000_0001, 8);
    add_tri(16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0, 16'sh8000, 16'sh7fff,
            32'haaaa_5555, 3);
    add_tri(16'sd8, 16'sd8, 16'sd24, 16'sd24, 16'sd56, 16'sd40, 32'h5555_aaaa, 2);

    n = 0;
    while (n < 1950) begin
      mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 3) == 0 ? 1 : 2);
      add_item(CMD_LOAD, mode);
      len = $urandom_range(0, 5) == 0 ? $urandom_range(0, 4) : $urandom_range(4, 30);
      for (int i = 0; i < len; i++) add_item(~CMD_LOAD, mode);
      n += len + 1;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && span_queue.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0 && span_queue.size() == 0) begin
      $display("** triangle_scanline_span_generator_unit: PASSED **");
    end else begin
      $display("** triangle_scanline_span_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule
